FILE: hdl/cidf_pkg.sv
package cidf_pkg;

  localparam int DEF_TABLE_SLOTS = 64;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam int HASH_SHIFT = 16;
  localparam int US_PER_MS = 1000;
  localparam int US_W = 42;            // 32-bit ms times 1000 fits in 42 bits
  localparam int IN_TDATA_W = 168;
  localparam int OUT_TDATA_W = 240;

  typedef logic [15:0] hash_t;

  typedef struct packed {
    logic [28:0] can_id;
    logic        is_extended;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic [63:0] receive_time_us;
  } frame_t;

  typedef struct packed {
    frame_t frame;
    hash_t  hash;
  } q_item_t;

  typedef struct packed {
    logic        publish;
    logic        table_full;
    logic        new_id;
    logic [7:0]  changed_mask;
    logic [31:0] seen_count;
    logic [31:0] change_count;
    logic [31:0] publish_count;
    logic [63:0] span_us;
    logic [31:0] frame_total;
    logic [31:0] overflow_total;
  } result_t;

  typedef struct packed {
    logic used;
    logic [28:0] ident;
    logic ext;
    logic [3:0] len;
    logic [63:0] data;
    logic [63:0] pub_data;
    logic [7:0] mask;
    logic [31:0] seen;
    logic [31:0] chg;
    logic [31:0] pcnt;
    logic [63:0] first_seen;
    logic [63:0] last_seen;
    logic [63:0] last_pub;
  } entry_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

  typedef enum logic [0:0] {
    REG_MIN_INTERVAL = 1'b0,
    REG_HEARTBEAT    = 1'b1
  } reg_idx_t;

endpackage

FILE: hdl/cidf_front.sv
module cidf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cidf_pkg::frame_t in_frame,
  output logic             push,
  output cidf_pkg::q_item_t push_item,
  input  logic             q_full
);
  import cidf_pkg::*;

  logic        st_valid;
  frame_t      st_frame;
  hash_t       st_hash;
  logic [31:0] prod;

  // Fibonacci hash: low 32 bits of the product, upper half kept.
  assign prod = {3'b000, in_frame.can_id} * HASH_MULT;

  assign push = st_valid && !q_full;
  assign in_ready = !st_valid || push;
  assign push_item = '{frame: st_frame, hash: st_hash};

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      st_frame <= in_frame;
      st_hash  <= prod[HASH_SHIFT +: 16];
    end
  end

endmodule

FILE: hdl/cidf_fifo.sv
module cidf_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cidf_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output cidf_pkg::q_item_t pop_item,
  output logic              valid
);
  import cidf_pkg::*;

  q_item_t    store [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign pop_item = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) store[wr_ptr] <= push_item;
  end

endmodule

FILE: hdl/cidf_back.sv
module cidf_back #(
  parameter int TABLE_SLOTS = cidf_pkg::DEF_TABLE_SLOTS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  cidf_pkg::q_item_t       q_item,
  output logic                    pop,
  input  logic [cidf_pkg::US_W-1:0] min_us,
  input  logic [cidf_pkg::US_W-1:0] hb_us,
  output logic                    res_valid,
  input  logic                    res_ready,
  output cidf_pkg::result_t       res,
  output cidf_pkg::back_stat_t    stat
);
  import cidf_pkg::*;

  localparam int IDX = $clog2(TABLE_SLOTS);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_ISSUE  = 6'b000100,
    S_LOOK   = 6'b001000,
    S_CALC   = 6'b010000,
    S_COMMIT = 6'b100000
  } state_t;

  state_t         state;
  entry_t         mem [TABLE_SLOTS];
  entry_t         rd_q;
  entry_t         ent;
  entry_t         wdata;
  entry_t         upd;
  frame_t         cur;
  logic [IDX-1:0] idx;
  logic [IDX-1:0] waddr;
  logic           we;
  logic [IDX:0]   probes;
  logic [IDX:0]   clr_idx;
  logic [31:0]    frame_counter;
  logic [31:0]    overflow_counter;
  logic           c_first;
  logic           c_differs;
  logic           c_pnew;
  logic [7:0]     c_mask;
  logic [63:0]    c_since;
  logic [7:0]     byte_diff;
  logic           throttled;
  logic           beat;
  logic           pub;

  assign pop = (state == S_IDLE) && q_valid && !res_valid;
  assign stat.clearing = (state == S_CLEAR);
  assign stat.busy = (state != S_CLEAR) && (state != S_IDLE);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_diff[b] = ent.data[8*b +: 8] != cur.payload[8*b +: 8];
    end
  end

  assign throttled = !c_first && (c_since < {22'd0, min_us});
  assign beat = (hb_us != '0) && !c_first && (c_since >= {22'd0, hb_us});
  assign pub = (c_pnew && !throttled) || beat;

  always_comb begin
    upd = ent;
    upd.len = cur.data_length;
    upd.data = cur.payload;
    upd.mask = c_mask;
    upd.seen = ent.seen + 32'd1;
    if (c_differs && !c_first) upd.chg = ent.chg + 32'd1;
    if (c_first) upd.first_seen = cur.receive_time_us;
    upd.last_seen = cur.receive_time_us;
    if (pub) begin
      upd.pub_data = cur.payload;
      upd.last_pub = cur.receive_time_us;
      upd.pcnt = ent.pcnt + 32'd1;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = idx;
    wdata = upd;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_idx[IDX-1:0];
      wdata = '0;
    end else if (state == S_COMMIT) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      res_valid <= 1'b0;
      frame_counter <= '0;
      overflow_counter <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (IDX+1)'(TABLE_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            cur <= q_item.frame;
            idx <= q_item.hash[IDX-1:0];
            probes <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          priority if (!rd_q.used) begin
            ent <= '{used: 1'b1, ident: cur.can_id, ext: cur.is_extended, default: '0};
            state <= S_CALC;
          end else if (rd_q.ident == cur.can_id && rd_q.ext == cur.is_extended) begin
            ent <= rd_q;
            state <= S_CALC;
          end else if (probes == (IDX+1)'(TABLE_SLOTS - 1)) begin
            frame_counter <= frame_counter + 32'd1;
            overflow_counter <= overflow_counter + 32'd1;
            res <= '{table_full: 1'b1,
                     frame_total: frame_counter + 32'd1,
                     overflow_total: overflow_counter + 32'd1,
                     default: '0};
            res_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
            probes <= probes + 1'b1;
            state <= S_ISSUE;
          end
        end
        S_CALC: begin
          c_first <= (ent.seen == 32'd0);
          c_differs <= (ent.len != cur.data_length) || (ent.data != cur.payload);
          c_mask <= (ent.seen == 32'd0) ? ent.mask : (ent.mask | byte_diff);
          c_pnew <= (ent.seen == 32'd0) || (ent.pub_data != cur.payload);
          c_since <= cur.receive_time_us - ent.last_pub;
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          frame_counter <= frame_counter + 32'd1;
          res.publish <= pub;
          res.table_full <= 1'b0;
          res.new_id <= c_first;
          res.changed_mask <= upd.mask;
          res.seen_count <= upd.seen;
          res.change_count <= upd.chg;
          res.publish_count <= upd.pcnt;
          res.span_us <= upd.last_seen - upd.first_seen;
          res.frame_total <= frame_counter + 32'd1;
          res.overflow_total <= overflow_counter;
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/can_id_table_publish_filter.sv
// Per-ID CAN frame table with a publish filter. Each input word is one CAN
// frame; each frame yields exactly one output word that says whether the
// frame should be published, along with the per-ID counters, the sticky mask
// of changed bytes, the time span of the ID and the global frame and overflow
// totals. A front stage hashes the identifier with a 32-bit Fibonacci
// multiply and places the frame in a two-entry queue; a back engine linearly
// probes a slot memory with one read and one write port and updates the slot.
// Frames are handled one at a time by the back engine: after the dequeue, each
// probe passes through a read-issue and a compare state, a hit goes on to
// the update calculation and commit states and the result is handed off, and
// a full table ends after the last compare with a table_full result. A stalled
// output word holds the engine in place until it is taken. The rate is set by
// the one read port of the slot memory. After reset the engine clears the slot
// memory, one slot per cycle, through all TABLE_SLOTS slots; frames are queued
// but not processed until that pass ends. TABLE_SLOTS must be a power of two.
// Registers: 0x0 min_interval_ms, 0x4 heartbeat_ms.
module can_id_table_publish_filter #(
  parameter int TABLE_SLOTS = cidf_pkg::DEF_TABLE_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // can_id[28:0], is_extended[29], data_length[33:30], payload[97:34],
  // receive_time_us[161:98], zero fill above
  input  logic [cidf_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // publish[0], table_full[1], new_id[2], changed_mask[10:3],
  // seen_count[42:11], change_count[74:43], publish_count[106:75],
  // span_us[170:107], frame_total[202:171], overflow_total[234:203], zero fill
  output logic [cidf_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cidf_pkg::*;

  frame_t     in_frame;
  logic       push;
  q_item_t    push_item;
  logic       q_full;
  logic       q_pop;
  q_item_t    q_item;
  logic       q_valid;
  result_t    res;
  back_stat_t stat;
  logic [31:0] min_interval_ms;
  logic [31:0] heartbeat_ms;
  logic [US_W-1:0] min_us;
  logic [US_W-1:0] hb_us;
  reg_idx_t   reg_sel;

  assign in_frame.can_id          = s_tdata[28:0];
  assign in_frame.is_extended     = s_tdata[29];
  assign in_frame.data_length     = s_tdata[33:30];
  assign in_frame.payload         = s_tdata[97:34];
  assign in_frame.receive_time_us = s_tdata[161:98];

  // Configuration registers. The millisecond limits are converted to
  // microseconds in a register stage so the compare path has no multiplier.
  assign pready = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval_ms <= '0;
      heartbeat_ms <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_MIN_INTERVAL: min_interval_ms <= pwdata;
        REG_HEARTBEAT:    heartbeat_ms <= pwdata;
        default: ;
      endcase
    end
    min_us <= US_W'(min_interval_ms) * US_W'(US_PER_MS);
    hb_us  <= US_W'(heartbeat_ms) * US_W'(US_PER_MS);
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_INTERVAL: prdata = min_interval_ms;
      REG_HEARTBEAT:    prdata = heartbeat_ms;
      default:          prdata = '0;
    endcase
  end

  cidf_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_frame(in_frame),
    .push(push), .push_item(push_item), .q_full(q_full)
  );

  cidf_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .push_item(push_item), .full(q_full),
    .pop(q_pop), .pop_item(q_item), .valid(q_valid)
  );

  cidf_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_item(q_item), .pop(q_pop),
    .min_us(min_us), .hb_us(hb_us),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(res), .stat(stat)
  );

  assign m_tdata = {5'd0, res.overflow_total, res.frame_total, res.span_us,
                    res.publish_count, res.change_count, res.seen_count,
                    res.changed_mask, res.new_id, res.table_full, res.publish};

  // A full-table result never publishes and never marks a new ID.
  a_full_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0] && !m_tdata[2])
    else $error("table_full result with publish or new_id set");

  // No result can appear while the slot memory is being cleared.
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !m_tvalid)
    else $error("result presented during clearing pass");

  // The engine only starts a frame once the output register is free.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !m_tvalid)
    else $error("result pending while engine is busy");

endmodule
